FILE: sv/bfs_pkg.sv
// Shared constants, types and a helper function for the free sector search block.
package bfs_pkg;

  // Map geometry
  localparam int TRACK_COUNT_DEF = 80;
  localparam int ENTRY_BYTES     = 6;
  localparam int IDX_W           = 9;
  localparam int TRACK_W         = 7;
  localparam int SECTOR_W        = 6;
  localparam logic [2:0] COUNT_OFF = 3'd0;
  localparam logic [2:0] LAST_OFF  = 3'(ENTRY_BYTES - 1);

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FIND  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_WRITTEN = 2'd0;
  localparam logic [1:0] ST_FOUND   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // Scan engine report to the controller
  typedef struct packed {
    logic                done;
    logic                found;
    logic [TRACK_W-1:0]  track;
    logic [SECTOR_W-1:0] sector;
  } scan_res_t;

  // Lowest set bit of a map byte (bit 0 has priority)
  function automatic logic [2:0] first_set(input logic [7:0] b);
    logic [2:0] pos;
    pos = '0;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) pos = 3'(i);
    end
    return pos;
  endfunction

endpackage

FILE: sv/bfs_ram.sv
// Generic single write port, single read port RAM with registered read data.
module bfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 480
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/bfs_scan.sv
// Scan engine: streams map bytes out of the RAM and tests each one with a shared bit finder.
module bfs_scan #(
  parameter int TRACK_COUNT = bfs_pkg::TRACK_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic [$clog2(TRACK_COUNT*bfs_pkg::ENTRY_BYTES)-1:0] rd_addr,
  input  logic [7:0]           rd_data,
  output bfs_pkg::scan_res_t   res
);
  import bfs_pkg::*;

  localparam int MAP_BYTES = TRACK_COUNT * ENTRY_BYTES;
  localparam int AW        = $clog2(MAP_BYTES);
  localparam int TW        = $clog2(TRACK_COUNT);
  localparam logic [TW-1:0] LAST_TRACK = TW'(TRACK_COUNT - 1);

  // Issue side: address sent to the RAM this cycle
  logic          active;
  logic          issue_done;
  logic [AW-1:0] issue_base;
  logic [2:0]    issue_off;
  logic [TW-1:0] issue_track;

  // Check side: tag of the byte arriving on rd_data
  logic          tag_valid;
  logic [AW-1:0] tag_base;
  logic [2:0]    tag_off;
  logic [TW-1:0] tag_track;

  logic          is_count, is_zero, last_track;
  logic          skip, hit, full_end, redirect, finish, issue_en;
  logic [TW:0]   track_plus;
  logic [2:0]    byte_num;

  assign rd_addr = issue_base + AW'(issue_off);

  // Byte classification
  assign is_count   = (tag_off == COUNT_OFF);
  assign is_zero    = (rd_data == 8'd0);
  assign last_track = (tag_track == LAST_TRACK);
  assign skip       = tag_valid & is_count & is_zero;
  assign hit        = tag_valid & !is_count & !is_zero;
  assign full_end   = tag_valid & last_track & is_zero & (is_count | (tag_off == LAST_OFF));
  assign redirect   = skip & !last_track;
  assign finish     = hit | full_end;
  assign issue_en   = active & !issue_done;
  assign track_plus = {1'b0, tag_track} + (TW+1)'(1);
  assign byte_num   = tag_off - 3'd1;

  always_ff @(posedge clk) begin
    res.done <= 1'b0;
    if (rst) begin
      active    <= 1'b0;
      tag_valid <= 1'b0;
    end else if (start) begin
      active      <= 1'b1;
      issue_done  <= 1'b0;
      issue_base  <= '0;
      issue_off   <= COUNT_OFF;
      issue_track <= '0;
      tag_valid   <= 1'b0;
    end else if (active) begin
      if (finish) begin
        // First free sector or end of map reached
        active     <= 1'b0;
        tag_valid  <= 1'b0;
        res.done   <= 1'b1;
        res.found  <= hit;
        res.track  <= hit ? TRACK_W'(track_plus) : '0;
        res.sector <= hit ? {byte_num, first_set(rd_data)} : '0;
      end else if (redirect) begin
        // Count byte is zero: drop the read in flight, jump to the next track
        issue_base  <= tag_base + AW'(ENTRY_BYTES);
        issue_track <= tag_track + TW'(1);
        issue_off   <= COUNT_OFF;
        tag_valid   <= 1'b0;
      end else begin
        tag_valid <= issue_en;
        if (issue_en) begin
          tag_base  <= issue_base;
          tag_off   <= issue_off;
          tag_track <= issue_track;
          if (issue_off == LAST_OFF) begin
            if (issue_track == LAST_TRACK) begin
              issue_done <= 1'b1;
            end else begin
              issue_base  <= issue_base + AW'(ENTRY_BYTES);
              issue_track <= issue_track + TW'(1);
              issue_off   <= COUNT_OFF;
            end
          end else begin
            issue_off <= issue_off + 3'd1;
          end
        end
      end
    end
  end

endmodule

FILE: sv/bam_free_sector_search.sv
// Top level: map store, clearing pass, transaction control and output register.
//
// Input channel (in_valid / in_stall): operation 0 writes byte_value into map byte
// byte_index (indices at or beyond TRACK_COUNT*6 store nothing); operation 1 asks
// for the first free sector. Every input transaction yields exactly one result on
// the output channel (out_valid / out_stall): status, found_track, found_sector.
// A map write's result goes to the pending result register, then to the output
// register once that is free. A find streams the map out of a single-read-port
// RAM, one byte per cycle, through one bit-finding check stage: a track whose
// count byte is zero is skipped after that byte, else its sector bytes are read
// until a set bit turns up or the map ends. One transaction is in work
// at a time; in_stall is high from acceptance until the result has been moved
// into the output register.
// After reset the map RAM is cleared one byte per cycle, all TRACK_COUNT*6 bytes,
// with in_stall high throughout.
// When the receiver holds out_stall, the result stays stable on the outputs;
// the block still takes the next transaction and works on it, and its result
// waits inside until the output register is free.
module bam_free_sector_search #(
  parameter int TRACK_COUNT = bfs_pkg::TRACK_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       operation,
  input  logic [8:0] byte_index,
  input  logic [7:0] byte_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [6:0] found_track,
  output logic [5:0] found_sector
);
  import bfs_pkg::*;

  localparam int MAP_BYTES = TRACK_COUNT * ENTRY_BYTES;
  localparam int AW        = $clog2(MAP_BYTES);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_DONE} state_t;

  state_t        state;
  logic [AW-1:0] clr_addr;
  logic          accept, in_range, scan_start, out_free;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  scan_res_t     scan_res;

  // Pending result
  logic [1:0]          res_status;
  logic [TRACK_W-1:0]  res_track;
  logic [SECTOR_W-1:0] res_sector;

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid & !in_stall;
  assign in_range   = (32'(byte_index) < 32'(MAP_BYTES));
  assign scan_start = accept & (operation == OP_FIND);
  assign out_free   = !out_valid | !out_stall;

  // RAM write port: clearing pass or map byte write
  assign ram_we    = (state == S_CLEAR) | (accept & (operation == OP_WRITE) & in_range);
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : AW'(byte_index);
  assign ram_wdata = (state == S_CLEAR) ? 8'd0 : byte_value;

  bfs_ram #(
    .WIDTH (8),
    .DEPTH (MAP_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bfs_scan #(
    .TRACK_COUNT (TRACK_COUNT)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (scan_start),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata),
    .res     (scan_res)
  );

  // Controller and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid & !out_stall) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(MAP_BYTES - 1)) state <= S_IDLE;
          clr_addr <= clr_addr + AW'(1);
        end
        S_IDLE: begin
          if (accept) begin
            if (operation == OP_FIND) begin
              state <= S_SCAN;
            end else begin
              res_status <= ST_WRITTEN;
              res_track  <= '0;
              res_sector <= '0;
              state      <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (scan_res.done) begin
            res_status <= scan_res.found ? ST_FOUND : ST_FULL;
            res_track  <= scan_res.track;
            res_sector <= scan_res.sector;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            found_track  <= res_track;
            found_sector <= res_sector;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The scan engine reports only while a find is in work
  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_res.done |-> state == S_SCAN)
    else $error("scan result outside a find");

  // An accepted find starts the scan
  a_find_scans: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_FIND) |=> state == S_SCAN)
    else $error("find did not enter scan");

  // A new result appears only from the pending result stage
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result without a pending transaction");

  // Map is never written while a scan reads it
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_IDLE))
    else $error("map write during scan");

  // Track and sector are zero unless a free sector was found
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_FOUND) |-> (found_track == '0 && found_sector == '0))
    else $error("nonzero location without a find");

endmodule

FILE: tb/bam_free_sector_search_tb.sv
// Self-checking testbench for the BAM free sector search block.
`timescale 1ns / 100ps

module bam_free_sector_search_tb;
  import bfs_pkg::*;

  localparam int TRACK_COUNT  = TRACK_COUNT_DEF;
  localparam int MAP_BYTES    = TRACK_COUNT * ENTRY_BYTES;
  localparam int RANDOM_ITEMS = 1800;
  localparam int DIR_ROWS     = 24;
  localparam int LONG_HOLD    = 300;
  localparam int MAX_REPORTS  = 40;

  typedef struct packed {
    logic [1:0]          status;
    logic [TRACK_W-1:0]  track;
    logic [SECTOR_W-1:0] sector;
  } sector_result_t;

  // One row of the directed table; res is only used when typed is set
  typedef struct packed {
    logic           op;
    logic [8:0]     idx;
    logic [7:0]     val;
    logic           typed;
    sector_result_t res;
  } dir_row_t;

  localparam sector_result_t WROTE = '{ST_WRITTEN, 7'd0, 6'd0};
  localparam sector_result_t FULL  = '{ST_FULL, 7'd0, 6'd0};
  localparam sector_result_t NONE  = '0;

  // Directed stimulus: empty map, single-bit extremes, count-zero skip,
  // count set with no free bits, writes past the end of the map
  dir_row_t dir_rows [0:DIR_ROWS-1] = '{
    '{OP_FIND,  9'd0,   8'h00, 1'b1, FULL},
    '{OP_WRITE, 9'd0,   8'hFF, 1'b1, WROTE},
    '{OP_FIND,  9'd0,   8'h00, 1'b1, FULL},
    '{OP_WRITE, 9'd5,   8'h80, 1'b1, WROTE},
    '{OP_FIND,  9'd0,   8'h00, 1'b1, '{ST_FOUND, 7'd1, 6'd39}},
    '{OP_WRITE, 9'd1,   8'h01, 1'b1, WROTE},
    '{OP_FIND,  9'd0,   8'h00, 1'b1, '{ST_FOUND, 7'd1, 6'd0}},
    '{OP_WRITE, 9'd0,   8'h00, 1'b1, WROTE},
    '{OP_FIND,  9'd0,   8'h00, 1'b1, FULL},
    '{OP_WRITE, 9'd479, 8'h80, 1'b1, WROTE},
    '{OP_WRITE, 9'd474, 8'h01, 1'b1, WROTE},
    '{OP_FIND,  9'd0,   8'h00, 1'b1, '{ST_FOUND, 7'd80, 6'd39}},
    '{OP_WRITE, 9'd481, 8'hFF, 1'b1, WROTE},
    '{OP_WRITE, 9'd480, 8'hFF, 1'b1, WROTE},
    '{OP_WRITE, 9'd511, 8'hFF, 1'b1, WROTE},
    '{OP_FIND,  9'd0,   8'h00, 1'b1, '{ST_FOUND, 7'd80, 6'd39}},
    '{OP_WRITE, 9'd6,   8'h10, 1'b1, WROTE},
    '{OP_WRITE, 9'd9,   8'h10, 1'b1, WROTE},
    '{OP_FIND,  9'd0,   8'h00, 1'b0, NONE},
    '{OP_WRITE, 9'd256, 8'hAA, 1'b1, WROTE},
    '{OP_WRITE, 9'd0,   8'hFF, 1'b1, WROTE},
    '{OP_FIND,  9'd0,   8'h00, 1'b0, NONE},
    '{OP_WRITE, 9'd1,   8'hFE, 1'b1, WROTE},
    '{OP_FIND,  9'd1,   8'h00, 1'b0, NONE}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       operation = OP_WRITE;
  logic [8:0] byte_index = '0;
  logic [7:0] byte_value = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] status;
  logic [6:0] found_track;
  logic [5:0] found_sector;

  // Tag travelling with the payload: typed expectation from the table
  logic           tag_typed = 1'b0;
  sector_result_t tag_res   = '0;

  // Predictor state and the results still owed by the block
  logic [7:0]     map_img [0:MAP_BYTES-1];
  sector_result_t owed_results [$];

  int  items_sent   = 0;
  int  results_seen = 0;
  int  writes_seen  = 0;
  int  finds_found  = 0;
  int  finds_full   = 0;
  int  errors       = 0;
  int  rx_wait      = 0;
  int  hold_cnt     = 0;
  bit  tx_burst     = 1'b0;
  bit  rx_burst     = 1'b0;
  bit  long_hold_req = 1'b0;
  int  long_holds   = 0;

  bam_free_sector_search #(.TRACK_COUNT(TRACK_COUNT)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .byte_index   (byte_index),
    .byte_value   (byte_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .found_track  (found_track),
    .found_sector (found_sector)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // First-fit scan over the predicted map
  function automatic sector_result_t search_first_free();
    sector_result_t res;
    int base;
    res = FULL;
    for (int t = 0; t < TRACK_COUNT; t++) begin
      base = t * ENTRY_BYTES;
      if (map_img[base] != 8'd0) begin
        for (int z = 0; z < ENTRY_BYTES - 1; z++) begin
          for (int b = 0; b < 8; b++) begin
            if (map_img[base + 1 + z][b]) begin
              res.status = ST_FOUND;
              res.track  = TRACK_W'(t + 1);
              res.sector = SECTOR_W'(z * 8 + b);
              return res;
            end
          end
        end
      end
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input int want, input int got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  // Result check, then prediction of each accepted transaction
  always @(posedge clk) begin
    sector_result_t got;
    sector_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{status, found_track, found_sector};
        if (owed_results.size() == 0) begin
          flag_mismatch("unexpected result, status", -1, got.status);
        end else begin
          want = owed_results.pop_front();
          if (got.status != want.status) flag_mismatch("status", want.status, got.status);
          if (got.track != want.track) flag_mismatch("found_track", want.track, got.track);
          if (got.sector != want.sector)
            flag_mismatch("found_sector", want.sector, got.sector);
        end
        results_seen++;
        rx_wait = rx_burst ? 0 : $urandom_range(0, 19);
      end
      if (in_valid && !in_stall) begin
        if (operation == OP_WRITE) begin
          if (byte_index < MAP_BYTES) map_img[byte_index] = byte_value;
          want = WROTE;
          writes_seen++;
        end else begin
          want = search_first_free();
          if (want.status == ST_FOUND) finds_found++;
          else finds_full++;
        end
        if (tag_typed) want = tag_res;
        owed_results.push_back(want);
      end
    end
  end

  // Receiver: per-result wait, plus the occasional long hold-off
  always @(negedge clk) begin
    if (long_hold_req) begin
      hold_cnt = LONG_HOLD;
      long_hold_req = 1'b0;
      long_holds++;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one transaction after a random gap and wait for it to be taken
  task automatic send_item(input logic op, input logic [8:0] idx, input logic [7:0] val,
                           input logic typed, input sector_result_t res);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    operation  <= op;
    byte_index <= idx;
    byte_value <= val;
    tag_typed  <= typed;
    tag_res    <= res;
    do @(posedge clk); while (!(in_valid && !in_stall));
    items_sent++;
  endtask

  task automatic write_byte(input int idx, input logic [7:0] val);
    send_item(OP_WRITE, 9'(idx), val, 1'b0, NONE);
  endtask

  task automatic send_noise();
    send_item(logic'($urandom_range(0, 1)), 9'($urandom_range(0, 511)),
              8'($urandom_range(0, 255)), 1'b0, NONE);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  // Make a track unusable: clear its count, or keep the count and clear its bits
  task automatic block_track(input int t);
    int base;
    bit has_bits;
    base = (t - 1) * ENTRY_BYTES;
    has_bits = 1'b0;
    for (int z = 1; z < ENTRY_BYTES; z++) if (map_img[base + z] != 8'd0) has_bits = 1'b1;
    if (map_img[base] != 8'd0 && has_bits) begin
      if ($urandom_range(0, 9) < 7) begin
        write_byte(base, 8'd0);
      end else begin
        for (int z = 1; z < ENTRY_BYTES; z++)
          if (map_img[base + z] != 8'd0) write_byte(base + z, 8'd0);
      end
    end
  endtask

  // Give a track its first free bit at the chosen sector
  task automatic open_track(input int t, input int sec);
    int base;
    int zb;
    int bt;
    logic [7:0] v;
    base = (t - 1) * ENTRY_BYTES;
    zb = sec / 8;
    bt = sec % 8;
    if (map_img[base] == 8'd0 || $urandom_range(0, 1) == 0)
      write_byte(base, 8'($urandom_range(1, 255)));
    for (int z = 0; z < ENTRY_BYTES - 1; z++) begin
      if (z < zb) begin
        if (map_img[base + 1 + z] != 8'd0) write_byte(base + 1 + z, 8'd0);
      end else if (z == zb) begin
        v = (8'($urandom_range(0, 255)) << bt) | (8'd1 << bt);
        write_byte(base + 1 + z, v);
      end else if ($urandom_range(0, 2) == 0) begin
        write_byte(base + 1 + z, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // One steered search: fill every track ahead of the target, open it, search
  task automatic run_search_case();
    int target;
    target = ($urandom_range(0, 9) == 0) ? TRACK_COUNT + 1 : $urandom_range(1, TRACK_COUNT);
    for (int t = 1; t < target; t++) block_track(t);
    if (target <= TRACK_COUNT) open_track(target, $urandom_range(0, 39));
    send_item(OP_FIND, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)), 1'b0, NONE);
    repeat ($urandom_range(0, 3)) send_noise();
  endtask

  // Main sequence
  initial begin
    bit hold_done;
    bit drain_done;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    foreach (map_img[i]) map_img[i] = 8'd0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++)
      send_item(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].val,
                dir_rows[i].typed, dir_rows[i].res);
    wait_drained();

    while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
      tx_burst = ($urandom_range(0, 4) == 0);
      rx_burst = ($urandom_range(0, 4) == 0);
      run_search_case();
      // Receiver holds off while the sender keeps pushing
      if (!hold_done && items_sent > 600) begin
        @(posedge clk);
        long_hold_req = 1'b1;
        tx_burst = 1'b1;
        repeat (12) send_noise();
        hold_done = 1'b1;
      end
      // Sender pauses until everything outstanding has come back
      if (!drain_done && items_sent > 1200) begin
        wait_drained();
        drain_done = 1'b1;
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    $display("Sent %0d transactions (%0d map writes), checked %0d results.",
             items_sent, writes_seen, results_seen);
    $display("Searches: %0d found a free sector, %0d reported a full disk; %0d long hold-offs.",
             finds_found, finds_full, long_holds);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
